/* design/srsc_pkg.sv */
package srsc_pkg;

	// Result kinds as seen on the kind port.
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_PATCH = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// Header positions that are restamped when a set closes.
	localparam logic [15:0] PATCH_POS_LEN_HI = 16'd0;
	localparam logic [15:0] PATCH_POS_LEN_LO = 16'd1;
	localparam logic [15:0] PATCH_POS_SEG    = 16'd4;

	// Totals of this size or more get a zeroed length field.
	localparam logic [16:0] LEN_FIELD_LIMIT = 17'd4096;

	// Everything one input transaction produces, handed from the decoder
	// to the output sequencer.
	typedef struct packed {
		logic        wr_valid;
		logic [15:0] wr_pos;
		logic [7:0]  wr_value;
		logic        wr_ovf;
		logic        close_valid;
		logic [7:0]  close_b0;
		logic [7:0]  close_b1;
		logic [16:0] close_total;
		logic        close_ovf;
	} bundle_t;

endpackage

/* design/segment_reassembly_size_count.sv */
// Segment reassembler: takes segmented mini-packets one byte per input
// transaction, header first, with seg_end on the last byte of each segment,
// and produces byte writes into a reassembled set. The first segment of a
// set writes its whole header (8 bytes, or 10 when the extension flag in
// byte 6 bit 3 is set); every segment writes its data bytes up to its
// length+2. When a segment whose segment nibble equals its size nibble
// ends, three header patches (positions 0, 1 and 4) and a completion
// result carrying the set length follow. Writes beyond MAX_SET_BYTES are
// dropped and reported through overflow. A byte transaction is decoded in
// the cycle it is accepted and its results land in an output register;
// results leave one per cycle while out_ready is high, and a byte that
// closes a set holds the register until its patches and completion have
// left. The output sequencer alone sets in_ready: a new byte is accepted
// in the same cycle as the last result of the previous one is taken.
module segment_reassembly_size_count #(
	parameter int MAX_SET_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  seg_byte,
	input  logic        seg_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] position,
	output logic [7:0]  value,
	output logic [16:0] set_length,
	output logic        overflow,
	output logic        run_last
);
	import srsc_pkg::*;

	bundle_t bundle;
	logic    accept;

	// A byte transaction completes when the sequencer can take the results
	// it produces, which includes the cycle its last pending result leaves.
	assign accept = in_valid && in_ready;

	// Header decode, set counters and patch values; all state updates on
	// an accepted byte.
	srsc_core #(
		.MAX_SET_BYTES(MAX_SET_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.seg_byte(seg_byte),
		.seg_end (seg_end),
		.bundle  (bundle)
	);

	// Result register and sequencer that walks the write, the patches and
	// the completion result out one per cycle while out_ready is high.
	srsc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.bundle    (bundle),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.position  (position),
		.value     (value),
		.set_length(set_length),
		.overflow  (overflow),
		.run_last  (run_last)
	);

endmodule

/* design/srsc_core.sv */
module srsc_core #(
	parameter int MAX_SET_BYTES = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        seg_byte,
	input  logic              seg_end,
	output srsc_pkg::bundle_t bundle
);
	import srsc_pkg::*;

	localparam int CNT_W = $clog2(MAX_SET_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SET_BYTES);
	localparam logic [12:0] POS_SAT = 13'd8191;

	logic             in_set_q;
	logic [CNT_W-1:0] count_q;
	logic [12:0]      byte_pos_q;
	logic [11:0]      seg_len_q;
	logic [3:0]       size_nib_q;
	logic [3:0]       seg_nib_q;
	logic             ext_q;
	logic [7:0]       first_byte_q;
	logic             drop_q;

	logic [11:0]      seg_len_n;
	logic [3:0]       size_nib_n;
	logic [3:0]       seg_nib_n;
	logic             ext_n;
	logic [7:0]       first_byte_n;
	logic             first;
	logic [3:0]       hdr_off;
	logic             wr;
	logic             emit;
	logic             drop_now;
	logic [CNT_W-1:0] count_n;
	logic [16:0]      total;
	logic [15:0]      len_field;
	logic             close;

	always_comb begin
		first        = !in_set_q;
		seg_len_n    = seg_len_q;
		size_nib_n   = size_nib_q;
		seg_nib_n    = seg_nib_q;
		ext_n        = ext_q;
		first_byte_n = first_byte_q;
		case (byte_pos_q)
			13'd0: begin
				seg_len_n  = {seg_byte[3:0], 8'h00};
				size_nib_n = 4'h0;
				seg_nib_n  = 4'h0;
				ext_n      = 1'b0;
				if (first) begin
					first_byte_n = seg_byte;
				end
			end
			13'd1: begin
				seg_len_n = seg_len_q | {4'h0, seg_byte};
			end
			13'd4: begin
				size_nib_n = seg_byte[7:4];
				seg_nib_n  = seg_byte[3:0];
			end
			13'd6: begin
				ext_n = seg_byte[3];
			end
			default: begin
			end
		endcase

		hdr_off = ext_n ? 4'd10 : 4'd8;
		if (byte_pos_q < 13'(hdr_off)) begin
			wr = first;
		end else begin
			wr = (byte_pos_q <= ({1'b0, seg_len_n} + 13'd2));
		end

		emit     = wr && (count_q < CNT_MAX);
		drop_now = wr && !(count_q < CNT_MAX);
		count_n  = count_q + CNT_W'(emit);
		total    = 17'(count_n);
		len_field = 16'(total - 17'd3);
		close    = seg_end && (seg_nib_n == size_nib_n);

		bundle.wr_valid    = emit;
		bundle.wr_pos      = 16'(count_q);
		bundle.wr_value    = seg_byte;
		bundle.wr_ovf      = drop_q;
		bundle.close_valid = close;
		bundle.close_total = total;
		bundle.close_ovf   = drop_q | drop_now;
		if (total < LEN_FIELD_LIMIT) begin
			bundle.close_b0 = {first_byte_n[7:4], len_field[11:8]};
			bundle.close_b1 = len_field[7:0];
		end else begin
			bundle.close_b0 = {first_byte_n[7:4], 4'h0};
			bundle.close_b1 = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_set_q     <= 1'b0;
			count_q      <= '0;
			byte_pos_q   <= '0;
			seg_len_q    <= '0;
			size_nib_q   <= '0;
			seg_nib_q    <= '0;
			ext_q        <= 1'b0;
			first_byte_q <= '0;
			drop_q       <= 1'b0;
		end else if (accept) begin
			seg_len_q    <= seg_len_n;
			size_nib_q   <= size_nib_n;
			seg_nib_q    <= seg_nib_n;
			ext_q        <= ext_n;
			first_byte_q <= first_byte_n;
			if (seg_end) begin
				byte_pos_q <= '0;
			end else if (byte_pos_q < POS_SAT) begin
				byte_pos_q <= byte_pos_q + 13'd1;
			end
			if (close) begin
				in_set_q <= 1'b0;
				count_q  <= '0;
				drop_q   <= 1'b0;
			end else begin
				if (seg_end) begin
					in_set_q <= 1'b1;
				end
				count_q <= count_n;
				drop_q  <= drop_q | drop_now;
			end
		end
	end

endmodule

/* design/srsc_emit.sv */
module srsc_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  srsc_pkg::bundle_t bundle,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [15:0]       position,
	output logic [7:0]        value,
	output logic [16:0]       set_length,
	output logic              overflow,
	output logic              run_last
);
	import srsc_pkg::*;

	typedef enum logic [2:0] {
		STEP_DATA,
		STEP_P0,
		STEP_P1,
		STEP_P4,
		STEP_DONE
	} step_t;

	bundle_t bnd_q;
	logic    full_q;
	step_t   step_q;
	logic    last;
	logic    take;

	always_comb begin
		kind       = KIND_PATCH;
		position   = 16'd0;
		value      = 8'd0;
		set_length = 17'd0;
		overflow   = bnd_q.close_ovf;
		last       = 1'b0;
		case (step_q)
			STEP_DATA: begin
				kind     = KIND_WRITE;
				position = bnd_q.wr_pos;
				value    = bnd_q.wr_value;
				overflow = bnd_q.wr_ovf;
				last     = !bnd_q.close_valid;
			end
			STEP_P0: begin
				position = PATCH_POS_LEN_HI;
				value    = bnd_q.close_b0;
			end
			STEP_P1: begin
				position = PATCH_POS_LEN_LO;
				value    = bnd_q.close_b1;
			end
			STEP_P4: begin
				position = PATCH_POS_SEG;
			end
			STEP_DONE: begin
				kind       = KIND_DONE;
				set_length = bnd_q.close_total;
				last       = 1'b1;
			end
			default: begin
			end
		endcase
		out_valid = full_q;
		run_last  = last;
		take      = full_q && out_ready;
		can_load  = !full_q || (out_ready && last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			step_q <= STEP_DATA;
		end else if (load) begin
			full_q <= bundle.wr_valid | bundle.close_valid;
			step_q <= bundle.wr_valid ? STEP_DATA : STEP_P0;
		end else if (take) begin
			if (last) begin
				full_q <= 1'b0;
			end else begin
				case (step_q)
					STEP_DATA: step_q <= STEP_P0;
					STEP_P0:   step_q <= STEP_P1;
					STEP_P1:   step_q <= STEP_P4;
					STEP_P4:   step_q <= STEP_DONE;
					default:   step_q <= STEP_DONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= bundle;
		end
	end

endmodule
